// File: hdl/pdec_pkg.sv
// ----------------------------------------------------------------------------
// pdec_pkg
// Shared types, character constants and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package pdec_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_F    = 8'h46;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_F    = 8'h66;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    // up to three result bytes produced by one input transaction
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } queue_head_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= DIGIT_0) && (c <= DIGIT_9)) ||
            ((c >= UPPER_A) && (c <= UPPER_F)) ||
            ((c >= LOWER_A) && (c <= LOWER_F));
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        logic [3:0] r;
        r = 4'd0;
        if ((c >= DIGIT_0) && (c <= DIGIT_9))
        begin
            d = c - DIGIT_0;
            r = d[3:0];
        end
        else if ((c >= UPPER_A) && (c <= UPPER_F))
        begin
            d = c - UPPER_A;
            r = d[3:0] + HEX_TEN;
        end
        else if ((c >= LOWER_A) && (c <= LOWER_F))
        begin
            d = c - LOWER_A;
            r = d[3:0] + HEX_TEN;
        end
        return r;
    endfunction

endpackage

// File: hdl/pdec_front.sv
// ----------------------------------------------------------------------------
// pdec_front
// Accepts input characters, tracks escape state and builds result bundles.
// ----------------------------------------------------------------------------
module pdec_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  pdec_pkg::in_item_t req_data,
    input  logic               queue_full,
    output logic               push,
    output pdec_pkg::bundle_t  push_data
);

    pdec_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       held_reg, held_next;
    logic             accept;
    logic             c_hex;
    logic [7:0]       c;
    logic [1:0]       n;
    logic             consumed;
    pdec_pkg::phase_t mid_ph;

    assign req_stall = queue_full;
    assign accept    = req_valid && !queue_full;
    assign c         = req_data.in_char;
    assign c_hex     = pdec_pkg::is_hex(c);

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            consumed   = 1'b0;
            phase_next = pdec_pkg::PH_IDLE;
            case (phase_reg)
                pdec_pkg::PH_PCT:
                begin
                    if (c_hex)
                    begin
                        held_next  = c;
                        phase_next = pdec_pkg::PH_DIGIT;
                        consumed   = 1'b1;
                    end
                end
                pdec_pkg::PH_DIGIT:
                begin
                    held_next = 8'd0;
                    consumed  = c_hex;
                end
                default:
                begin
                end
            endcase
            if (!consumed && (c == pdec_pkg::PCT_CHAR))
                phase_next = pdec_pkg::PH_PCT;
            if (req_data.in_last)
            begin
                phase_next = pdec_pkg::PH_IDLE;
                held_next  = 8'd0;
            end
        end
        else
        begin
            consumed = 1'b0;
        end
    end

    always_comb
    begin
        push_data.bytes = '0;
        n               = 2'd0;
        mid_ph          = pdec_pkg::PH_IDLE;
        case (phase_reg)
            pdec_pkg::PH_PCT:
            begin
                if (c_hex)
                    mid_ph = pdec_pkg::PH_DIGIT;
                else
                begin
                    push_data.bytes[n] = pdec_pkg::PCT_CHAR;
                    n = n + 2'd1;
                end
            end
            pdec_pkg::PH_DIGIT:
            begin
                if (c_hex)
                begin
                    push_data.bytes[n] = {pdec_pkg::hex_val(held_reg), pdec_pkg::hex_val(c)};
                    n = n + 2'd1;
                end
                else
                begin
                    push_data.bytes[n] = pdec_pkg::PCT_CHAR;
                    n = n + 2'd1;
                    push_data.bytes[n] = held_reg;
                    n = n + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
        if (!((phase_reg == pdec_pkg::PH_PCT || phase_reg == pdec_pkg::PH_DIGIT) && c_hex))
        begin
            if (c == pdec_pkg::PCT_CHAR)
                mid_ph = pdec_pkg::PH_PCT;
            else
            begin
                push_data.bytes[n] = (c == pdec_pkg::PLUS_CHAR) ? pdec_pkg::SPACE_CHAR : c;
                n = n + 2'd1;
            end
        end
        if (req_data.in_last)
        begin
            if (mid_ph == pdec_pkg::PH_PCT || mid_ph == pdec_pkg::PH_DIGIT)
            begin
                push_data.bytes[n] = pdec_pkg::PCT_CHAR;
                n = n + 2'd1;
            end
            if (mid_ph == pdec_pkg::PH_DIGIT)
            begin
                push_data.bytes[n] = c;
                n = n + 2'd1;
            end
        end
        push_data.cnt  = n;
        push_data.last = req_data.in_last;
        push           = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pdec_pkg::PH_IDLE;
            held_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: hdl/pdec_queue.sv
// ----------------------------------------------------------------------------
// pdec_queue
// Small bundle queue between the front and back parts.
// ----------------------------------------------------------------------------
module pdec_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pdec_pkg::bundle_t     push_data,
    input  logic                  pop,
    output logic                  full,
    output pdec_pkg::queue_head_t head
);

    pdec_pkg::bundle_t                 mem [pdec_pkg::QUEUE_DEPTH];
    logic [pdec_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [pdec_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [pdec_pkg::QUEUE_CW-1:0]     count_reg, count_next;
    logic                              do_push, do_pop;

    assign full       = (count_reg == pdec_pkg::QUEUE_CW'(pdec_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/pdec_back.sv
// ----------------------------------------------------------------------------
// pdec_back
// Takes bundles from the queue and sends their bytes out one per transaction.
// ----------------------------------------------------------------------------
module pdec_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdec_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output pdec_pkg::out_item_t   rsp_data
);

    pdec_pkg::bundle_t cur_reg, cur_next;
    logic              busy_reg, busy_next;
    logic [1:0]        idx_reg, idx_next;
    logic              at_end, done, take;

    assign at_end             = ((idx_reg + 2'd1) == cur_reg.cnt);
    assign rsp_valid          = busy_reg;
    assign rsp_data.out_char  = cur_reg.bytes[idx_reg];
    assign rsp_data.out_last  = cur_reg.last && at_end;
    assign done               = busy_reg && !rsp_stall && at_end;
    assign take               = !busy_reg || done;
    assign pop                = take && head.valid;

    always_comb
    begin
        cur_next  = cur_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            busy_next = head.valid;
            cur_next  = head.data;
            idx_next  = 2'd0;
        end
        else if (busy_reg && !rsp_stall)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

// File: hdl/percent_decoder_stream.sv
// ----------------------------------------------------------------------------
// percent_decoder_stream
// Streaming URL percent decoder, form style ('+' decodes to space).
// ----------------------------------------------------------------------------
//  channel | signals                        | carries
//  req     | req_valid, req_stall, req_data | one raw character and end flag
//  rsp     | rsp_valid, rsp_stall, rsp_data | one decoded byte and end flag
//  One character is taken per cycle unless req_stall; each yields 0 to 3
//  bytes, sent one per cycle from the back part unless rsp_stall, so
//  output bytes per cycle bound the rate. A four-entry bundle queue
//  decouples the two sides; req_stall is high only while it is full.
//  Reset clears escape state and the queue.
// ----------------------------------------------------------------------------
module percent_decoder_stream (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pdec_pkg::in_item_t  req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output pdec_pkg::out_item_t rsp_data
);

    logic                  queue_full;
    logic                  push;
    logic                  pop;
    pdec_pkg::bundle_t     push_data;
    pdec_pkg::queue_head_t head;

    pdec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    pdec_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .head      (head)
    );

    pdec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for percent_decoder_stream. A scoreboard class
// predicts the decoded bytes of every accepted input transaction and checks
// each response transaction in order. Directed strings cover the hex digit
// ranges, '+', bad escapes and escapes cut off by the end flag. Random
// strings follow, under random gaps, a long receiver hold and drain pauses.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 80;
    localparam int SEG_ITEMS   = 60;
    localparam int NUM_SEGS    = 7;

    class pdec_scoreboard;
        pdec_pkg::out_item_t expected_q[$];
        pdec_pkg::phase_t    esc_phase;
        logic [7:0]          held_char;
        int unsigned         mismatches;

        function new();
            esc_phase  = pdec_pkg::PH_IDLE;
            held_char  = 8'h00;
            mismatches = 0;
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39)
                return int'(c) - 'h30;
            if (c >= 8'h41 && c <= 8'h46)
                return int'(c) - 'h41 + 10;
            if (c >= 8'h61 && c <= 8'h66)
                return int'(c) - 'h61 + 10;
            return -1;
        endfunction

        function pdec_pkg::out_item_t plain(logic [7:0] c);
            pdec_pkg::out_item_t r;
            r.out_char = c;
            r.out_last = 1'b0;
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        function void note_input(pdec_pkg::in_item_t it);
            pdec_pkg::out_item_t step_q[$];
            logic [7:0]          c;
            int                  v;
            int                  hi;
            bit                  consumed;
            c        = it.in_char;
            v        = digit_value(c);
            consumed = 1'b0;
            case (esc_phase)
                pdec_pkg::PH_PCT:
                begin
                    if (v >= 0)
                    begin
                        held_char = c;
                        esc_phase = pdec_pkg::PH_DIGIT;
                        consumed  = 1'b1;
                    end
                    else
                    begin
                        step_q.insert(step_q.size(), plain(pdec_pkg::PCT_CHAR));
                        esc_phase = pdec_pkg::PH_IDLE;
                    end
                end
                pdec_pkg::PH_DIGIT:
                begin
                    if (v >= 0)
                    begin
                        hi = digit_value(held_char);
                        if (hi < 0)
                            hi = 0;
                        step_q.insert(step_q.size(), plain(8'(hi * 16 + v)));
                        consumed = 1'b1;
                    end
                    else
                    begin
                        step_q.insert(step_q.size(), plain(pdec_pkg::PCT_CHAR));
                        step_q.insert(step_q.size(), plain(held_char));
                    end
                    esc_phase = pdec_pkg::PH_IDLE;
                    held_char = 8'h00;
                end
                default:
                    esc_phase = pdec_pkg::PH_IDLE;
            endcase
            if (!consumed)
            begin
                if (c == pdec_pkg::PCT_CHAR)
                    esc_phase = pdec_pkg::PH_PCT;
                else
                    step_q.insert(step_q.size(),
                                  plain((c == pdec_pkg::PLUS_CHAR) ?
                                        pdec_pkg::SPACE_CHAR : c));
            end
            if (it.in_last)
            begin
                if (esc_phase == pdec_pkg::PH_PCT || esc_phase == pdec_pkg::PH_DIGIT)
                    step_q.insert(step_q.size(), plain(pdec_pkg::PCT_CHAR));
                if (esc_phase == pdec_pkg::PH_DIGIT)
                    step_q.insert(step_q.size(), plain(held_char));
                esc_phase = pdec_pkg::PH_IDLE;
                held_char = 8'h00;
                if (step_q.size() > 0)
                    step_q[step_q.size() - 1].out_last = 1'b1;
            end
            foreach (step_q[i])
                expected_q.insert(expected_q.size(), step_q[i]);
        endfunction

        task check_result(pdec_pkg::out_item_t got);
            pdec_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected byte %02h last %0b", got.out_char, got.out_last));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_char !== want.out_char)
                report($sformatf("out_char %02h, want %02h", got.out_char, want.out_char));
            if (got.out_last !== want.out_last)
                report($sformatf("out_last %0b, want %0b (byte %02h)",
                                 got.out_last, want.out_last, want.out_char));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    pdec_pkg::in_item_t  req_data;
    logic                rsp_valid;
    logic                rsp_stall;
    pdec_pkg::out_item_t rsp_data;

    pdec_scoreboard sb;
    int unsigned    cycles;
    int unsigned    items_sent;
    int             hold_cycles;
    bit             tx_gaps_on;
    bit             rx_gaps_on;

    percent_decoder_stream u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
    end

    // receiver: random stall per transaction, long hold on request
    initial
    begin
        int gap;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                while (hold_cycles > 0)
                begin
                    @(posedge clk);
                    hold_cycles--;
                end
            end
            gap = rx_gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rsp_valid && !rsp_stall) && hold_cycles == 0);
        end
    end

    task drive_item(pdec_pkg::in_item_t it);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_input(it);
        items_sent++;
    endtask

    task send_char(logic [7:0] c, bit last);
        pdec_pkg::in_item_t it;
        it.in_char = c;
        it.in_last = last;
        drive_item(it);
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function logic [7:0] rand_hex();
        case ($urandom_range(0, 2))
            0:       return 8'(8'h30 + $urandom_range(0, 9));
            1:       return 8'(8'h41 + $urandom_range(0, 5));
            default: return 8'(8'h61 + $urandom_range(0, 5));
        endcase
    endfunction

    function logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (sb.digit_value(c) >= 0);
        return c;
    endfunction

    task send_random_string();
        logic [7:0] chars[$];
        int         ntok;
        ntok = $urandom_range(1, 6);
        repeat (ntok)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: chars.insert(chars.size(), 8'($urandom_range(0, 255)));
                3:       chars.insert(chars.size(), pdec_pkg::PLUS_CHAR);
                4, 5, 6:
                begin
                    chars.insert(chars.size(), pdec_pkg::PCT_CHAR);
                    chars.insert(chars.size(), rand_hex());
                    chars.insert(chars.size(), rand_hex());
                end
                7:
                begin
                    chars.insert(chars.size(), pdec_pkg::PCT_CHAR);
                    chars.insert(chars.size(), rand_non_hex());
                end
                8:
                begin
                    chars.insert(chars.size(), pdec_pkg::PCT_CHAR);
                    chars.insert(chars.size(), rand_hex());
                    chars.insert(chars.size(), rand_non_hex());
                end
                default:
                begin
                    chars.insert(chars.size(), pdec_pkg::PCT_CHAR);
                    if ($urandom_range(0, 1))
                        chars.insert(chars.size(), rand_hex());
                end
            endcase
        end
        foreach (chars[i])
            send_char(chars[i], i == chars.size() - 1);
    endtask

    task wait_drained();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int unsigned target;
        sb          = new();
        cycles      = 0;
        items_sent  = 0;
        hold_cycles = 0;
        tx_gaps_on  = 1'b1;
        rx_gaps_on  = 1'b1;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("%4E");
        send_text("%fa+");
        send_text("%G");
        send_text("%4Z");
        send_text("%%4");
        send_text("%");
        send_text("%0");
        send_text("a%9%");
        wait_drained();

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            tx_gaps_on = (seg == 0 || seg == 2) ? 1'b0 : 1'($urandom_range(0, 1));
            rx_gaps_on = (seg == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            if (seg == 2)
                hold_cycles = HOLD_LEN;
            target = items_sent + SEG_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_random_string();
                else
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected bytes never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
